// File: rtl/core/rbi_pkg.sv
// ----------------------------------------------------------------------------
// rbi_pkg: shared types and constants for the rigid body integrator
// Word layouts, register indexes, pipeline stage numbers and fixed-point
// constants used by the integrator pipeline and its damping lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

  // Field widths
  localparam int FIELD_W  = 63;
  localparam int DT_W     = 16;
  localparam int DRAG_W   = 16;
  localparam int FLAG_W   = 3;
  localparam int DRAG_DT_W = 32;
  localparam int F_W      = 25;   // drag factor, Q0.24 up to and including 1.0

  // Flag bits
  localparam int FLAG_KINEMATIC = 0;
  localparam int FLAG_GRAVITY   = 1;
  localparam int FLAG_FROZEN    = 2;

  // Configuration registers
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRAVITY   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP = 1'd1;
  localparam logic [DT_W-1:0] TIME_STEP_RESET = 16'd1092;

  // Fixed-point constants
  localparam int FRAC_BITS = 10;
  localparam logic [DRAG_DT_W-1:0] DRAG_ONE_Q24 = 32'h0100_0000;
  localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754936;
  localparam int TURN_Q10    = 360 << FRAC_BITS;
  localparam int SLEEP_LIMIT = 105;  // sum of squares below this is at rest
  localparam int WRAP_STEPS  = 6;
  localparam int K_W         = $clog2(WRAP_STEPS + 1);

  // Pipeline stages
  localparam int STG_IN      = 1;  // input register
  localparam int STG_MUL     = 2;  // gravity and drag products
  localparam int STG_DRAG    = 3;  // gravity applied, drag factor formed
  localparam int STG_SCALE   = 4;  // vector times drag factor
  localparam int STG_ROUND   = 5;  // rounded and saturated
  localparam int STG_SQUARE  = 6;  // squares, displacement products
  localparam int STG_SLEEP   = 7;  // rest test, rotation product
  localparam int STG_ADVANCE = 8;  // position and angle advanced
  localparam int STG_OUT     = 9;  // output register
  localparam int NUM_STAGES  = STG_OUT;

  typedef logic [NUM_STAGES:1] stage_en_t;

  typedef struct packed {
    logic [FIELD_W-1:0] lin_velocity;
    logic [FIELD_W-1:0] body_position;
    logic [FIELD_W-1:0] ang_velocity;
    logic [FIELD_W-1:0] euler_degrees;
    logic [DRAG_W-1:0]  linear_drag;
    logic [DRAG_W-1:0]  angular_drag;
    logic [FLAG_W-1:0]  body_flags;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] new_lin_velocity;
    logic [FIELD_W-1:0] new_position;
    logic [FIELD_W-1:0] new_ang_velocity;
    logic [FIELD_W-1:0] new_euler_degrees;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/core/rbi_damp.sv
// ----------------------------------------------------------------------------
// rbi_damp: drag and rest lane
// Scales a three-component vector by max(0, 1 - drag*dt), rounds and
// saturates, then zeroes it when its squared length falls below 0.0001.
// ----------------------------------------------------------------------------
`default_nettype none

module rbi_damp
  import rbi_pkg::*;
#(
  parameter int COMPONENT_BITS = 21
)
(
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic [3*COMPONENT_BITS-1:0]   vec_in,     // taken at STG_DRAG
  input  logic [DRAG_DT_W-1:0]          drag_dt,    // taken at STG_DRAG
  output logic [3*COMPONENT_BITS-1:0]   damped_vec, // at STG_ROUND
  output logic [3*COMPONENT_BITS-1:0]   rest_vec,   // at STG_SLEEP
  output logic                          asleep      // at STG_SLEEP
);

  localparam int CB      = COMPONENT_BITS;
  localparam int PROD_W  = CB + 25;
  localparam int PRODX_W = PROD_W + 1;
  localparam int RND_W   = PRODX_W - 24;
  localparam int SQ_W    = 2 * CB;
  localparam int SUM_W   = SQ_W + 2;

  localparam logic signed [PRODX_W-1:0] HALF24  = PRODX_W'(1 << 23);
  localparam logic signed [RND_W-1:0]   COMP_HI = RND_W'((1 << (CB - 1)) - 1);
  localparam logic signed [RND_W-1:0]   COMP_LO = RND_W'(-(1 << (CB - 1)));

  function automatic logic signed [CB-1:0] sat_rnd(input logic signed [RND_W-1:0] x);
    priority if (x > COMP_HI) begin
      return COMP_HI[CB-1:0];
    end else if (x < COMP_LO) begin
      return COMP_LO[CB-1:0];
    end else begin
      return x[CB-1:0];
    end
  endfunction

  logic signed [CB-1:0]     v3_r [3];
  logic [F_W-1:0]           f3_r;
  logic [F_W-1:0]           f_nxt;
  logic signed [PROD_W-1:0] prod4_r [3];
  logic signed [CB-1:0]     v5_r [3];
  logic signed [CB-1:0]     v5_nxt [3];
  logic signed [PRODX_W-1:0] rnd_t [3];
  logic signed [SQ_W-1:0]   sq6_r [3];
  logic signed [CB-1:0]     v6_r [3];
  logic signed [SUM_W-1:0]  sum_c;
  logic                     asleep_nxt;
  logic [3*CB-1:0]          rest_r;
  logic                     asleep_r;

  // drag factor, clamped at zero
  always_comb begin
    f_nxt = (drag_dt >= DRAG_ONE_Q24) ? '0 : F_W'(DRAG_ONE_Q24 - drag_dt);
  end

  always_ff @(posedge clk) begin
    if (en[STG_DRAG]) begin
      for (int i = 0; i < 3; i++) begin
        v3_r[i] <= $signed(vec_in[i*CB +: CB]);
      end
      f3_r <= f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SCALE]) begin
      for (int i = 0; i < 3; i++) begin
        prod4_r[i] <= PROD_W'(v3_r[i]) * $signed(PROD_W'(f3_r));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_t[i]  = PRODX_W'(prod4_r[i]) + HALF24;
      v5_nxt[i] = sat_rnd($signed(rnd_t[i][PRODX_W-1:24]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_ROUND]) begin
      v5_r <= v5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SQUARE]) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= SQ_W'(v5_r[i]) * SQ_W'(v5_r[i]);
      end
      v6_r <= v5_r;
    end
  end

  always_comb begin
    sum_c      = SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
    asleep_nxt = (sum_c < SUM_W'(SLEEP_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (en[STG_SLEEP]) begin
      asleep_r <= asleep_nxt;
      for (int i = 0; i < 3; i++) begin
        rest_r[i*CB +: CB] <= asleep_nxt ? '0 : v6_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      damped_vec[i*CB +: CB] = v5_r[i];
    end
  end

  assign rest_vec = rest_r;
  assign asleep   = asleep_r;

endmodule

`default_nettype wire

// File: rtl/core/rigid_body_integrate_top.sv
// Pipeline: nine register stages; an accepted word passes through them all and
//   shows on out_word, with out_valid high, held there while out_stall is high.
// Throughput: one body per cycle; a stalled output only holds the stages that
//   are full, so bubbles still close up and input keeps flowing behind them.
// Reset (rst_n low, synchronous): all stage valid bits cleared, gravity_vector
//   cleared, time_step back to 1092 (one sixtieth of a second).
// ----------------------------------------------------------------------------
// rigid_body_integrate_top: semi-implicit Euler step for one rigid body
// Nine-stage pipeline: gravity, drag, rest test, position and rotation
// advance with bounded angle wrap, saturated Q10.10 results.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_integrate_top
  import rbi_pkg::*;
#(
  parameter int COMPONENT_BITS = 21
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]    cfg_data
);

  localparam int CB      = COMPONENT_BITS;
  localparam int VEC_W   = 3 * CB;
  // dt products: signed component times unsigned Q0.16
  localparam int GDT_W   = CB + 16;
  localparam int GDTX_W  = GDT_W + 1;
  // rotation product: w*dt times degrees-per-radian in Q.16
  localparam int ROT_W   = CB + 38;
  localparam int ROTX_W  = ROT_W + 1;
  // working width for sums and the angle wrap (must also hold 6 turns)
  localparam int ANG_W   = (CB + 9 > 25) ? CB + 9 : 25;

  localparam logic signed [GDTX_W-1:0] HALF16  = GDTX_W'(1 << 15);
  localparam logic signed [ROTX_W-1:0] HALF32  = ROTX_W'({1'b1, 31'd0});
  localparam logic signed [ANG_W-1:0]  COMP_HI = ANG_W'((1 << (CB - 1)) - 1);
  localparam logic signed [ANG_W-1:0]  COMP_LO = ANG_W'(-(1 << (CB - 1)));
  localparam logic signed [ANG_W-1:0]  TURN    = ANG_W'(TURN_Q10);

  function automatic logic signed [CB-1:0] sat_comp(input logic signed [ANG_W-1:0] x);
    priority if (x > COMP_HI) begin
      return COMP_HI[CB-1:0];
    end else if (x < COMP_LO) begin
      return COMP_LO[CB-1:0];
    end else begin
      return x[CB-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] gravity_r;
  logic [DT_W-1:0]    time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r   <= '0;
      time_step_r <= TIME_STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRAVITY:   gravity_r   <= cfg_data;
        CFG_TIME_STEP: time_step_r <= cfg_data[DT_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage control: each stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NUM_STAGES:1] valid_r;
  logic [NUM_STAGES:1] valid_nxt;
  stage_en_t           en;

  always_comb begin
    en[NUM_STAGES] = !valid_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[STG_IN] = en[STG_IN] ? in_valid : valid_r[STG_IN];
    for (int k = STG_IN + 1; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !en[STG_IN];
  assign out_valid = valid_r[STG_OUT];

  // raw word carried alongside for pass-through and late operands
  in_word_t word_r [STG_IN:STG_ADVANCE];

  always_ff @(posedge clk) begin
    if (en[STG_IN]) begin
      word_r[STG_IN] <= in_word;
    end
    for (int k = STG_IN + 1; k <= STG_ADVANCE; k++) begin
      if (en[k]) begin
        word_r[k] <= word_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gravity*dt and drag*dt products
  // --------------------------------------------------------------------------
  logic signed [GDT_W-1:0] gdt2_r [3];
  logic [DRAG_DT_W-1:0]    ldt2_r;
  logic [DRAG_DT_W-1:0]    adt2_r;

  always_ff @(posedge clk) begin
    if (en[STG_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        gdt2_r[i] <= GDT_W'($signed(gravity_r[i*CB +: CB]))
                   * $signed(GDT_W'(time_step_r));
      end
      ldt2_r <= DRAG_DT_W'(word_r[STG_IN].linear_drag) * DRAG_DT_W'(time_step_r);
      adt2_r <= DRAG_DT_W'(word_r[STG_IN].angular_drag) * DRAG_DT_W'(time_step_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 input: gravity step applied when enabled
  // --------------------------------------------------------------------------
  logic signed [GDTX_W-1:0] grav_t [3];
  logic signed [ANG_W-1:0]  grav_sum [3];
  logic [VEC_W-1:0]         lin_in_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grav_t[i]   = GDTX_W'(gdt2_r[i]) + HALF16;
      grav_sum[i] = ANG_W'($signed(word_r[STG_MUL].lin_velocity[i*CB +: CB]))
                  + ANG_W'($signed(grav_t[i][GDTX_W-1:16]));
      if (word_r[STG_MUL].body_flags[FLAG_GRAVITY]) begin
        lin_in_c[i*CB +: CB] = sat_comp(grav_sum[i]);
      end else begin
        lin_in_c[i*CB +: CB] = word_r[STG_MUL].lin_velocity[i*CB +: CB];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3-7: drag and rest lanes
  // --------------------------------------------------------------------------
  logic [VEC_W-1:0] lin_damped;
  logic [VEC_W-1:0] lin_rest;
  logic             lin_asleep;
  logic [VEC_W-1:0] ang_damped;
  logic [VEC_W-1:0] ang_rest;
  logic             ang_asleep;

  rbi_damp #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_lin_damp (
    .clk        (clk),
    .en         (en),
    .vec_in     (lin_in_c),
    .drag_dt    (ldt2_r),
    .damped_vec (lin_damped),
    .rest_vec   (lin_rest),
    .asleep     (lin_asleep)
  );

  rbi_damp #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_ang_damp (
    .clk        (clk),
    .en         (en),
    .vec_in     (word_r[STG_MUL].ang_velocity[VEC_W-1:0]),
    .drag_dt    (adt2_r),
    .damped_vec (ang_damped),
    .rest_vec   (ang_rest),
    .asleep     (ang_asleep)
  );

  // --------------------------------------------------------------------------
  // Stage 6: v*dt and w*dt on the damped (pre-rest) vectors
  // --------------------------------------------------------------------------
  logic signed [GDT_W-1:0] vdt6_r [3];
  logic signed [GDT_W-1:0] wdt6_r [3];

  always_ff @(posedge clk) begin
    if (en[STG_SQUARE]) begin
      for (int i = 0; i < 3; i++) begin
        vdt6_r[i] <= GDT_W'($signed(lin_damped[i*CB +: CB])) * $signed(GDT_W'(time_step_r));
        wdt6_r[i] <= GDT_W'($signed(ang_damped[i*CB +: CB])) * $signed(GDT_W'(time_step_r));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: moved position (before rest test) and degrees product
  // --------------------------------------------------------------------------
  logic signed [GDTX_W-1:0] pos_t [3];
  logic signed [ANG_W-1:0]  pos_sum [3];
  logic signed [CB-1:0]     padv7_r [3];
  logic signed [ROT_W-1:0]  rot7_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_t[i]   = GDTX_W'(vdt6_r[i]) + HALF16;
      pos_sum[i] = ANG_W'($signed(word_r[STG_SQUARE].body_position[i*CB +: CB]))
                 + ANG_W'($signed(pos_t[i][GDTX_W-1:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SLEEP]) begin
      for (int i = 0; i < 3; i++) begin
        padv7_r[i] <= sat_comp(pos_sum[i]);
        rot7_r[i]  <= ROT_W'(wdt6_r[i]) * $signed(ROT_W'(DEG_PER_RAD_Q16));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: rest test applied, angle advanced (unwrapped)
  // --------------------------------------------------------------------------
  logic signed [ROTX_W-1:0] rot_t [3];
  logic signed [ANG_W-1:0]  ang_step [3];
  logic signed [ANG_W-1:0]  a8_r [3];
  logic [VEC_W-1:0]         pos8_r;
  logic [VEC_W-1:0]         vel8_r;
  logic [VEC_W-1:0]         angw8_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_t[i]    = ROTX_W'(rot7_r[i]) + HALF32;
      ang_step[i] = ang_asleep ? '0 : ANG_W'($signed(rot_t[i][ROTX_W-1:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_ADVANCE]) begin
      for (int i = 0; i < 3; i++) begin
        a8_r[i] <= ANG_W'($signed(word_r[STG_SLEEP].euler_degrees[i*CB +: CB]))
                 + ang_step[i];
        // a body at rest does not move
        pos8_r[i*CB +: CB] <= lin_asleep ? word_r[STG_SLEEP].body_position[i*CB +: CB]
                                         : padv7_r[i];
      end
      vel8_r  <= lin_rest;
      angw8_r <= ang_rest;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: bounded wrap into [0, 360], saturation and output assembly.
  // Subtract count = number of thresholds 1..6 turns exceeded; add count =
  // number of thresholds 0..-5 turns undershot. The two never both apply.
  // --------------------------------------------------------------------------
  logic [WRAP_STEPS-1:0]   over_c [3];
  logic [WRAP_STEPS-1:0]   under_c [3];
  logic [K_W-1:0]          ksub_c [3];
  logic [K_W-1:0]          kadd_c [3];
  logic signed [ANG_W-1:0] wrap_c [3];
  logic [VEC_W-1:0]        rot_out_c;
  out_word_t               out_nxt;
  out_word_t               out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int m = 1; m <= WRAP_STEPS; m++) begin
        over_c[i][m-1]  = (a8_r[i] > $signed(ANG_W'(TURN_Q10 * m)));
        under_c[i][m-1] = (a8_r[i] < $signed(ANG_W'(-(TURN_Q10 * (m - 1)))));
      end
      ksub_c[i] = K_W'($countones(over_c[i]));
      kadd_c[i] = K_W'($countones(under_c[i]));
      priority if (over_c[i][0]) begin
        wrap_c[i] = a8_r[i] - TURN * $signed(ANG_W'(ksub_c[i]));
      end else if (under_c[i][0]) begin
        wrap_c[i] = a8_r[i] + TURN * $signed(ANG_W'(kadd_c[i]));
      end else begin
        wrap_c[i] = a8_r[i];
      end
      rot_out_c[i*CB +: CB] = sat_comp(wrap_c[i]);
    end

    if (word_r[STG_ADVANCE].body_flags[FLAG_KINEMATIC]) begin
      // kinematic bodies pass through untouched
      out_nxt.new_lin_velocity  = word_r[STG_ADVANCE].lin_velocity;
      out_nxt.new_position      = word_r[STG_ADVANCE].body_position;
      out_nxt.new_ang_velocity  = word_r[STG_ADVANCE].ang_velocity;
      out_nxt.new_euler_degrees = word_r[STG_ADVANCE].euler_degrees;
    end else begin
      out_nxt.new_lin_velocity = FIELD_W'(vel8_r);
      out_nxt.new_position     = FIELD_W'(pos8_r);
      if (word_r[STG_ADVANCE].body_flags[FLAG_FROZEN]) begin
        out_nxt.new_ang_velocity  = word_r[STG_ADVANCE].ang_velocity;
        out_nxt.new_euler_degrees = word_r[STG_ADVANCE].euler_degrees;
      end else begin
        out_nxt.new_ang_velocity  = FIELD_W'(angw8_r);
        out_nxt.new_euler_degrees = FIELD_W'(rot_out_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

`ifndef NO_ASSERTIONS
  // input is held off only when every stage is full and the output is stalled
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("input stalled while the pipeline has room");

  // words in flight change only by what enters and leaves
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) == $past($countones(valid_r))
      + $past(int'(in_valid && !in_stall)) - $past(int'(out_valid && !out_stall))))
    else $error("word lost or duplicated in the pipeline");
`endif

endmodule

`default_nettype wire
